/* design/tts_pkg.sv */
package tts_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned FRAC_BITS    = 24;
    localparam int unsigned ROWS_MAX_DEF = 64;
    localparam int unsigned WORD_BITS_DEF = 32;
    localparam int unsigned IDX_W        = 6;
    localparam int unsigned ERR_W        = 2;
    localparam int unsigned DIVQ_W       = DATA_W + FRAC_BITS;   // quotient magnitude bits
    localparam int unsigned IN_TDATA_W   = 4 * DATA_W;
    localparam int unsigned OUT_TDATA_W  = ((DATA_W + IDX_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_PIVOT = 2'd1,
        ERR_SAT   = 2'd2,
        ERR_ROWS  = 2'd3
    } t_err;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FWD_RD,
        S_MUL1,
        S_SUB1,
        S_MUL2,
        S_SUB2,
        S_DIVC,
        S_WAITC,
        S_DIVD,
        S_WAITD,
        S_WR,
        S_BS0,
        S_BS1,
        S_BSW,
        S_BSM,
        S_BSS,
        S_EM_RD,
        S_EM_LD,
        S_EM_OUT
    } t_state;

    typedef struct packed {
        logic                     ovf;
        logic signed [DATA_W-1:0] val;
    } t_sat;

    // Clamp a wide value to a signed word of eff bits.
    function automatic t_sat sat_word(input logic signed [63:0] v, input int unsigned eff);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        t_sat               res;
        hi = (64'sd1 <<< (eff - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        res.ovf = 1'b0;
        res.val = v[DATA_W-1:0];
        if (v > hi) begin
            res.ovf = 1'b1;
            res.val = hi[DATA_W-1:0];
        end else if (v < lo) begin
            res.ovf = 1'b1;
            res.val = lo[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

/* design/tts_div.sv */
module tts_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [tts_pkg::DATA_W-1:0]     i_num,
    input  logic signed [tts_pkg::DATA_W-1:0]     i_den,
    output logic                                  o_done,
    output logic signed [tts_pkg::DIVQ_W:0]       o_quot
);
    import tts_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVQ_W + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DATA_W:0]       r_rem, n_rem;
    logic [DIVQ_W-1:0]     r_dq, n_dq;
    logic [DATA_W-1:0]     r_mag_d, n_mag_d;
    logic                  r_neg, n_neg;
    logic [DATA_W:0]       rem_sh;
    logic [DATA_W-1:0]     mag_n;

    // Restoring division on magnitudes, one quotient bit per cycle.
    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_dq    = r_dq;
        n_mag_d = r_mag_d;
        n_neg   = r_neg;
        mag_n   = i_num[DATA_W-1] ? DATA_W'(-i_num) : DATA_W'(i_num);
        rem_sh  = {r_rem[DATA_W-1:0], r_dq[DIVQ_W-1]};
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = CNT_W'(DIVQ_W);
            n_rem   = '0;
            n_dq    = {mag_n, {FRAC_BITS{1'b0}}};
            n_mag_d = i_den[DATA_W-1] ? DATA_W'(-i_den) : DATA_W'(i_den);
            n_neg   = i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_mag_d}) begin
                n_rem = rem_sh - {1'b0, r_mag_d};
                n_dq  = {r_dq[DIVQ_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_dq  = {r_dq[DIVQ_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt   <= n_cnt;
        r_rem   <= n_rem;
        r_dq    <= n_dq;
        r_mag_d <= n_mag_d;
        r_neg   <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});

endmodule

/* design/tridiagonal_thomas_solver.sv */
// Channel   Dir  tdata fields (low bit up)               tlast        tuser
// s_axis    in   lower, diag, upper, rhs (32 bits each)   last_row     -
// m_axis    out  x_value[31:0], row_index[37:32], pad     last_result  error_code[1:0]
//
// Each row after the first reads the stored terms of the row before and
// forms two products on the shared multiplier; every row then forms up to
// two quotients on the bit-serial divider (the final row needs no upper
// one). Back substitution walks from the last row to row zero, and the
// results leave on m_axis in that order, each held until taken. Reset is
// synchronous and active low and clears the state, the row count, the error
// code and the output valid; the coefficient stores are not cleared.
// s_axis_tready is low while a row or a solve is busy.
module tridiagonal_thomas_solver #(
    parameter int unsigned ROWS_MAX  = tts_pkg::ROWS_MAX_DEF,
    parameter int unsigned WORD_BITS = tts_pkg::WORD_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // lower[31:0], diag[63:32], upper[95:64], rhs[127:96]
    input  logic [tts_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    input  logic                                 s_axis_tlast,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // x_value[31:0], row_index[37:32], zero pad above
    output logic [tts_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // error_code[1:0]
    output logic [tts_pkg::ERR_W-1:0]            m_axis_tuser,
    output logic                                 m_axis_tlast,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready
);
    import tts_pkg::*;

    // The arithmetic word width is clamped to between 16 bits and the width of the data fields.
    localparam int unsigned EFF = (WORD_BITS < 16) ? 16 : ((WORD_BITS > 32) ? 32 : WORD_BITS);
    localparam int unsigned AW  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int unsigned CW  = $clog2(ROWS_MAX + 1);

    // Modified upper coefficients and right-hand sides. During back
    // substitution the solution overwrites the right-hand side of each row.
    logic signed [DATA_W-1:0] mem_cp [ROWS_MAX];
    logic signed [DATA_W-1:0] mem_dp [ROWS_MAX];

    t_state                   r_state, n_state;
    logic signed [DATA_W-1:0] r_a, n_a, r_b, n_b, r_c, n_c, r_d, n_d;
    logic                     r_last, n_last;
    logic signed [DATA_W-1:0] r_piv, n_piv, r_num, n_num, r_cp, n_cp, r_dp, n_dp;
    logic signed [DATA_W-1:0] r_xprev, n_xprev;
    logic signed [63:0]       r_prod, n_prod;
    logic [AW-1:0]            r_addr, n_addr;
    logic [CW-1:0]            r_cnt, n_cnt, r_n, n_n;
    t_err                     r_err, n_err;
    logic                     r_ovalid, n_ovalid, r_olast, n_olast;
    logic signed [DATA_W-1:0] r_ox, n_ox;
    logic [IDX_W-1:0]         r_oidx, n_oidx;
    logic signed [DATA_W-1:0] r_cp_q, r_dp_q;

    logic                     wr_cp, wr_dp;
    logic [AW-1:0]            wr_addr;
    logic signed [DATA_W-1:0] wr_cp_val, wr_dp_val;

    logic signed [DATA_W-1:0] mul_x, mul_y;
    logic signed [63:0]       diff;
    t_sat                     sat_r, sat_a, sat_b, sat_c, sat_d;
    logic                     div_start, div_done;
    logic signed [DATA_W-1:0] div_num;
    logic signed [DIVQ_W:0]   div_quot;

    tts_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_piv),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // The one multiplier, shared by the forward and the backward sweep.
    always_comb begin
        mul_x = r_a;
        mul_y = r_cp_q;
        unique case (r_state)
            S_MUL2:  mul_y = r_dp_q;
            S_BSM: begin
                mul_x = r_cp_q;
                mul_y = r_xprev;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_c       = r_c;
        n_d       = r_d;
        n_last    = r_last;
        n_piv     = r_piv;
        n_num     = r_num;
        n_cp      = r_cp;
        n_dp      = r_dp;
        n_xprev   = r_xprev;
        n_prod    = mul_x * mul_y;
        n_addr    = r_addr;
        n_cnt     = r_cnt;
        n_n       = r_n;
        n_err     = r_err;
        n_ovalid  = r_ovalid;
        n_olast   = r_olast;
        n_ox      = r_ox;
        n_oidx    = r_oidx;
        wr_cp     = 1'b0;
        wr_dp     = 1'b0;
        wr_addr   = r_addr;
        wr_cp_val = r_cp;
        wr_dp_val = r_dp;
        div_start = 1'b0;
        div_num   = r_c;
        sat_a     = sat_word(64'(signed'(s_axis_tdata[DATA_W-1:0])), EFF);
        sat_b     = sat_word(64'(signed'(s_axis_tdata[2*DATA_W-1:DATA_W])), EFF);
        sat_c     = sat_word(64'(signed'(s_axis_tdata[3*DATA_W-1:2*DATA_W])), EFF);
        sat_d     = sat_word(64'(signed'(s_axis_tdata[4*DATA_W-1:3*DATA_W])), EFF);
        diff      = 64'(r_b) - (r_prod >>> FRAC_BITS);
        unique case (r_state)
            S_SUB2: diff = 64'(r_d) - (r_prod >>> FRAC_BITS);
            S_BSS:  diff = 64'(r_dp_q) - (r_prod >>> FRAC_BITS);
            default: ;
        endcase
        sat_r = sat_word(diff, EFF);
        if (r_state == S_WAITC || r_state == S_WAITD) begin
            sat_r = sat_word(64'(div_quot), EFF);
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_last = s_axis_tlast;
                    if (r_cnt >= CW'(ROWS_MAX)) begin
                        // The store is full: the row is dropped.
                        if (r_err == ERR_NONE) n_err = ERR_ROWS;
                        if (s_axis_tlast) begin
                            n_n     = CW'(ROWS_MAX);
                            n_addr  = AW'(ROWS_MAX - 1);
                            n_state = S_BS0;
                        end
                    end else begin
                        n_a = sat_a.val;
                        n_b = sat_b.val;
                        n_c = sat_c.val;
                        n_d = sat_d.val;
                        if (r_err == ERR_NONE &&
                            (sat_a.ovf || sat_b.ovf || sat_c.ovf || sat_d.ovf)) begin
                            n_err = ERR_SAT;
                        end
                        if (r_cnt == '0) begin
                            n_piv   = sat_b.val;
                            n_num   = sat_d.val;
                            n_state = S_DIVC;
                        end else begin
                            n_addr  = AW'(r_cnt - CW'(1));
                            n_state = S_FWD_RD;
                        end
                    end
                end
            end
            S_FWD_RD: n_state = S_MUL1;
            S_MUL1:   n_state = S_SUB1;
            S_SUB1: begin
                n_piv = sat_r.val;
                if (sat_r.ovf && r_err == ERR_NONE) n_err = ERR_SAT;
                n_state = S_MUL2;
            end
            S_MUL2: n_state = S_SUB2;
            S_SUB2: begin
                n_num = sat_r.val;
                if (sat_r.ovf && r_err == ERR_NONE) n_err = ERR_SAT;
                n_state = S_DIVC;
            end
            S_DIVC: begin
                if (r_last) begin
                    // The upper term of the final row plays no part.
                    n_cp    = '0;
                    n_state = S_DIVD;
                end else if (r_piv == '0) begin
                    n_cp    = '0;
                    if (r_err == ERR_NONE) n_err = ERR_PIVOT;
                    n_state = S_DIVD;
                end else begin
                    div_start = 1'b1;
                    div_num   = r_c;
                    n_state   = S_WAITC;
                end
            end
            S_WAITC: begin
                if (div_done) begin
                    n_cp = sat_r.val;
                    if (sat_r.ovf && r_err == ERR_NONE) n_err = ERR_SAT;
                    n_state = S_DIVD;
                end
            end
            S_DIVD: begin
                if (r_piv == '0) begin
                    n_dp    = '0;
                    if (r_err == ERR_NONE) n_err = ERR_PIVOT;
                    n_state = S_WR;
                end else begin
                    div_start = 1'b1;
                    div_num   = r_num;
                    n_state   = S_WAITD;
                end
            end
            S_WAITD: begin
                if (div_done) begin
                    n_dp = sat_r.val;
                    if (sat_r.ovf && r_err == ERR_NONE) n_err = ERR_SAT;
                    n_state = S_WR;
                end
            end
            S_WR: begin
                wr_cp   = 1'b1;
                wr_dp   = 1'b1;
                wr_addr = r_cnt[AW-1:0];
                n_cnt   = r_cnt + CW'(1);
                if (r_last) begin
                    n_n     = r_cnt + CW'(1);
                    n_addr  = r_cnt[AW-1:0];
                    n_state = S_BS0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_BS0: n_state = S_BS1;
            S_BS1: begin
                // The last row's solution is its modified right-hand side.
                n_xprev = r_dp_q;
                if (r_n == CW'(1)) begin
                    n_addr  = AW'(r_n - CW'(1));
                    n_state = S_EM_RD;
                end else begin
                    n_addr  = AW'(r_n - CW'(2));
                    n_state = S_BSW;
                end
            end
            S_BSW: n_state = S_BSM;
            S_BSM: n_state = S_BSS;
            S_BSS: begin
                wr_dp     = 1'b1;
                wr_dp_val = sat_r.val;
                n_xprev   = sat_r.val;
                if (sat_r.ovf && r_err == ERR_NONE) n_err = ERR_SAT;
                if (r_addr == '0) begin
                    n_addr  = AW'(r_n - CW'(1));
                    n_state = S_EM_RD;
                end else begin
                    n_addr  = r_addr - AW'(1);
                    n_state = S_BSW;
                end
            end
            S_EM_RD: n_state = S_EM_LD;
            S_EM_LD: begin
                n_ox     = r_dp_q;
                n_oidx   = IDX_W'(r_addr);
                n_olast  = (r_addr == '0);
                n_ovalid = 1'b1;
                n_state  = S_EM_OUT;
            end
            S_EM_OUT: begin
                if (m_axis_tready) begin
                    n_ovalid = 1'b0;
                    if (r_olast) begin
                        n_cnt   = '0;
                        n_err   = ERR_NONE;
                        n_state = S_IDLE;
                    end else begin
                        n_addr  = r_addr - AW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_err    <= ERR_NONE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_err    <= n_err;
            r_ovalid <= n_ovalid;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_c     <= n_c;
        r_d     <= n_d;
        r_last  <= n_last;
        r_piv   <= n_piv;
        r_num   <= n_num;
        r_cp    <= n_cp;
        r_dp    <= n_dp;
        r_xprev <= n_xprev;
        r_prod  <= n_prod;
        r_addr  <= n_addr;
        r_n     <= n_n;
        r_olast <= n_olast;
        r_ox    <= n_ox;
        r_oidx  <= n_oidx;
    end

    always_ff @(posedge i_clk) begin
        if (wr_cp) mem_cp[wr_addr] <= wr_cp_val;
        if (wr_dp) mem_dp[wr_addr] <= wr_dp_val;
        r_cp_q <= mem_cp[r_addr];
        r_dp_q <= mem_dp[r_addr];
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = r_err;
    assign m_axis_tdata  = OUT_TDATA_W'({r_oidx, r_ox});

endmodule
